/* rtl/core/hsv_to_rgb_pixel_defines.svh */
// assertion macros for the hsv to rgb pixel converter
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

// overlapping implication, checked on every clock edge out of reset
`define HSVRGB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_pixel assertion failed");

// implication with a fixed latency in cycles
`define HSVRGB_ASSERT_AFTER(label, ante, cycles, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##cycles (cons)) \
    else $error("hsv_to_rgb_pixel latency assertion failed");

`endif

/* rtl/core/hsvrgb_pkg.sv */
// constants, types and helper functions for the hsv to rgb pixel converter
package hsvrgb_pkg;

  localparam logic [7:0]  FullScale    = 8'd255;
  localparam logic [5:0]  SectorSpan   = 6'd60;
  localparam logic [2:0]  SectorCount  = 3'd6;
  localparam logic [7:0]  AlphaByte    = 8'hFF;
  localparam logic [14:0] Recip60      = 15'd17477;
  localparam int          Recip60Shift = 20;
  localparam int          Latency      = 6;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

  // hue / 60 for a 9-bit hue, by constant compares
  function automatic logic [3:0] hue_quotient(input logic [8:0] h);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if (h >= 9'(k * 60)) begin
        q = q + 4'd1;
      end
    end
    return q;
  endfunction

  // exact floor(x / 255) for x up to 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

/* rtl/core/hsv_to_rgb_pixel.sv */
// hsv to rgb pixel converter, six-stage pipeline with packed rgba output
//
// One pixel is taken on every clock where start is high; busy is always low.
// Each result appears on red, green, blue and packed_pixel once its request has
// passed all stages, marked by a one-cycle done pulse, at one pixel per clock.
// The receiver cannot hold results off, so it must take every done cycle.
// The six register stages, in order: hue split, saturation products,
// divide by 60, factor forming, brightness products, divide by 255 and select.
module hsv_to_rgb_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [8:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [31:0] packed_pixel
);

  // stage valids
  logic v1, v2, v3, v4, v5;

  // stage 1: hue split
  logic [3:0]          quot_next;
  logic [8:0]          quot_x60;
  logic [5:0]          frac_next;
  hsvrgb_pkg::sector_t sector_next;
  hsvrgb_pkg::sector_t s1_sector;
  logic [5:0]          s1_frac;
  logic [7:0]          s1_sat;
  logic [7:0]          s1_val;

  // stage 2: saturation products
  hsvrgb_pkg::sector_t s2_sector;
  logic [13:0]         s2_sf;
  logic [13:0]         s2_sc;
  logic [7:0]          s2_pf;
  logic [7:0]          s2_val;

  // stage 3: divide by 60
  logic [28:0]         mq;
  logic [28:0]         mt;
  hsvrgb_pkg::sector_t s3_sector;
  logic [7:0]          s3_aq;
  logic [7:0]          s3_at;
  logic [7:0]          s3_pf;
  logic [7:0]          s3_val;

  // stage 4: factors
  hsvrgb_pkg::sector_t s4_sector;
  logic [7:0]          s4_pf;
  logic [7:0]          s4_qf;
  logic [7:0]          s4_tf;
  logic [7:0]          s4_val;

  // stage 5: brightness products
  hsvrgb_pkg::sector_t s5_sector;
  logic [15:0]         s5_pp;
  logic [15:0]         s5_qp;
  logic [15:0]         s5_tp;
  logic [7:0]          s5_val;

  // stage 6: final select
  logic [7:0] p_ch, q_ch, t_ch;
  logic [7:0] red_next, green_next, blue_next;

  assign busy = 1'b0;

  always_comb begin
    quot_next = hsvrgb_pkg::hue_quotient(hue);
    quot_x60  = 9'(quot_next) * 9'(hsvrgb_pkg::SectorSpan);
    frac_next = 6'(hue - quot_x60);
    if (quot_next >= 4'(hsvrgb_pkg::SectorCount)) begin
      sector_next = hsvrgb_pkg::sector_t'(3'(quot_next - 4'(hsvrgb_pkg::SectorCount)));
    end else begin
      sector_next = hsvrgb_pkg::sector_t'(quot_next[2:0]);
    end
  end

  assign mq = 29'(s2_sf) * 29'(hsvrgb_pkg::Recip60);
  assign mt = 29'(s2_sc) * 29'(hsvrgb_pkg::Recip60);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    s1_sector <= sector_next;
    s1_frac   <= frac_next;
    s1_sat    <= saturation;
    s1_val    <= brightness;

    s2_sector <= s1_sector;
    s2_sf     <= 14'(s1_sat) * 14'(s1_frac);
    s2_sc     <= 14'(s1_sat) * 14'(hsvrgb_pkg::SectorSpan - s1_frac);
    s2_pf     <= hsvrgb_pkg::FullScale - s1_sat;
    s2_val    <= s1_val;

    s3_sector <= s2_sector;
    s3_aq     <= mq[hsvrgb_pkg::Recip60Shift +: 8];
    s3_at     <= mt[hsvrgb_pkg::Recip60Shift +: 8];
    s3_pf     <= s2_pf;
    s3_val    <= s2_val;

    s4_sector <= s3_sector;
    s4_pf     <= s3_pf;
    s4_qf     <= hsvrgb_pkg::FullScale - s3_aq;
    s4_tf     <= hsvrgb_pkg::FullScale - s3_at;
    s4_val    <= s3_val;

    s5_sector <= s4_sector;
    s5_pp     <= 16'(s4_val) * 16'(s4_pf);
    s5_qp     <= 16'(s4_val) * 16'(s4_qf);
    s5_tp     <= 16'(s4_val) * 16'(s4_tf);
    s5_val    <= s4_val;

    red       <= red_next;
    green     <= green_next;
    blue      <= blue_next;
  end

  always_comb begin
    p_ch = hsvrgb_pkg::div255(s5_pp);
    q_ch = hsvrgb_pkg::div255(s5_qp);
    t_ch = hsvrgb_pkg::div255(s5_tp);
    unique case (s5_sector)
      hsvrgb_pkg::SEC_RED_YELLOW: begin
        red_next = s5_val; green_next = t_ch;   blue_next = p_ch;
      end
      hsvrgb_pkg::SEC_YELLOW_GREEN: begin
        red_next = q_ch;   green_next = s5_val; blue_next = p_ch;
      end
      hsvrgb_pkg::SEC_GREEN_CYAN: begin
        red_next = p_ch;   green_next = s5_val; blue_next = t_ch;
      end
      hsvrgb_pkg::SEC_CYAN_BLUE: begin
        red_next = p_ch;   green_next = q_ch;   blue_next = s5_val;
      end
      hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
        red_next = t_ch;   green_next = p_ch;   blue_next = s5_val;
      end
      default: begin
        red_next = s5_val; green_next = p_ch;   blue_next = q_ch;
      end
    endcase
  end

  assign packed_pixel = {red, green, blue, hsvrgb_pkg::AlphaByte};

endmodule

/* rtl/core/hsvrgb_checker.sv */
// port-level checker for the hsv to rgb pixel converter, bound to the top level
`include "hsv_to_rgb_pixel_defines.svh"

module hsvrgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [8:0]  hue,
  input logic [7:0]  saturation,
  input logic [7:0]  brightness,
  input logic        done,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [31:0] packed_pixel
);

  logic [8:0] hue_seen;

  assign hue_seen = hue;

  `HSVRGB_ASSERT_AFTER(a_request_gives_result, start && !busy && hue_seen <= 9'd511, 6, done)
  `HSVRGB_ASSERT_NOW(a_result_has_request, done, $past(start, hsvrgb_pkg::Latency))
  `HSVRGB_ASSERT_NOW(a_packed_matches, done, packed_pixel[31:24] == red && packed_pixel[23:16] == green && packed_pixel[15:8] == blue && packed_pixel[7:0] == hsvrgb_pkg::AlphaByte)
  `HSVRGB_ASSERT_NOW(a_grey_on_zero_sat, done && $past(saturation, hsvrgb_pkg::Latency) == 8'd0, red == green && green == blue && red == $past(brightness, hsvrgb_pkg::Latency))

endmodule

bind hsv_to_rgb_pixel hsvrgb_checker u_hsvrgb_checker (.*);
